// ===== hw/rtl/fbe_pkg.sv =====
// Shared constants, widths and the base64 character function for the fragment encoder.
`timescale 1ns / 1ps

package fbe_pkg;

  localparam int unsigned DATA_W        = 8;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned FRAG_SIZE_W   = 11;
  localparam int unsigned SEXTET_W      = 6;
  localparam int unsigned CARRY_W       = 4;
  localparam int unsigned MAX_CHARS     = 4;
  localparam int unsigned CNT_W         = 3;

  localparam int unsigned MAX_FRAGMENT_DEF = 1024;

  localparam logic [FRAG_SIZE_W-1:0] FRAG_SIZE_RST = 11'd512;

  // APB register map: one register, one word each
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_FRAGMENT_SIZE = 1'b0;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3d;  // '='

  // Map a six-bit group onto the standard alphabet A-Z a-z 0-9 + /
  function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
    logic [CHAR_W-1:0] c;
    if (v inside {[6'd0:6'd25]}) begin
      c = 8'h41 + CHAR_W'(v);
    end else if (v inside {[6'd26:6'd51]}) begin
      c = 8'h61 + CHAR_W'(v) - 8'd26;
    end else if (v inside {[6'd52:6'd61]}) begin
      c = 8'h30 + CHAR_W'(v) - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2b;  // '+'
    end else begin
      c = 8'h2f;  // '/'
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/fbe_in_if.sv =====
// Input channel: one message byte per word with its end-of-message flag.
`timescale 1ns / 1ps

interface fbe_in_if;
  logic                       valid;
  logic                       ready;
  logic [fbe_pkg::DATA_W-1:0] data_byte;
  logic                       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
  modport mon    (input valid, input data_byte, input end_of_message, input ready);
endinterface

// ===== hw/rtl/fbe_out_if.sv =====
// Result channel: one base64 character per word with fragment and message flags.
`timescale 1ns / 1ps

interface fbe_out_if;
  logic                       valid;
  logic                       ready;
  logic [fbe_pkg::CHAR_W-1:0] text_char;
  logic                       end_of_fragment;
  logic                       end_of_text;
  logic                       run_last;

  modport source (output valid, output text_char, output end_of_fragment,
                  output end_of_text, output run_last, input ready);
  modport sink   (input valid, input text_char, input end_of_fragment,
                  input end_of_text, input run_last, output ready);
  modport mon    (input valid, input text_char, input end_of_fragment,
                  input end_of_text, input run_last, input ready);
endinterface

// ===== hw/rtl/fragmented_base64_encoder.sv =====
// Top level of the fragmented base64 encoder with its APB register.
`timescale 1ns / 1ps
// Datapath: an accepted byte's characters are written into the character buffer; each
//   character then moves from the head of the buffer into the output register.
// Throughput: one character per cycle while the output is taken; a byte makes one to four
//   characters, and the single output register drains them from the buffer.
// Reset: synchronous, active low; clears group phase, carry, fragment position and both
//   valid paths, and loads fragment_size with 512.

module fragmented_base64_encoder #(
  parameter int unsigned MAX_FRAGMENT = fbe_pkg::MAX_FRAGMENT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fbe_in_if.sink                          in_ch,
  fbe_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fbe_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fbe_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fbe_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import fbe_pkg::*;

  // Fragment position must hold MAX_FRAGMENT itself; compares run at the wider of the two.
  localparam int unsigned POS_W = $clog2(MAX_FRAGMENT + 1);
  localparam int unsigned CMP_W = (POS_W > FRAG_SIZE_W) ? POS_W : FRAG_SIZE_W;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD
  } phase_t;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [FRAG_SIZE_W-1:0] frag_size_r;
  logic                   cfg_wr;
  logic                   cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_FRAGMENT_SIZE);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign prdata  = cfg_hit ? CFG_DATA_W'(frag_size_r) : '0;

  // ---------------------------------------------------------------------------
  // Encoder state
  // ---------------------------------------------------------------------------
  phase_t                 phase_r, phase_nxt;
  logic [CARRY_W-1:0]     carry_r, carry_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;

  // Character buffer: holds every character of the byte last accepted
  logic [MAX_CHARS-1:0][CHAR_W-1:0] buf_char_r;
  logic [CNT_W-1:0]                 buf_cnt_r;
  logic                             buf_eof_r;
  logic                             buf_eot_r;

  // Output register
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_eof_r;
  logic              out_eot_r;
  logic              out_last_r;

  logic in_acc;
  logic move;   // buffer head advances into the output register

  assign move         = (buf_cnt_r != '0) && (!out_valid_r || out_ch.ready);
  // Take a new byte whenever the buffer empties by this edge, even with a word waiting
  assign in_ch.ready  = (buf_cnt_r == '0) || ((buf_cnt_r == CNT_W'(1)) && move);
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.text_char       = out_char_r;
  assign out_ch.end_of_fragment = out_eof_r;
  assign out_ch.end_of_text     = out_eot_r;
  assign out_ch.run_last        = out_last_r;

  // ---------------------------------------------------------------------------
  // Encode one byte: group split, fragment boundary, padding
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0]                 frag_limit;
  logic [CMP_W-1:0]                 size_ext;
  logic [POS_W-1:0]                 pos_inc;
  logic                             frag_end;
  logic [MAX_CHARS-1:0][CHAR_W-1:0] enc_char;
  logic [CNT_W-1:0]                 enc_cnt;
  logic [DATA_W-1:0]                b;

  assign b        = in_ch.data_byte;
  assign size_ext = CMP_W'(frag_size_r);

  always_comb begin
    // Clamp the configured size into 1..MAX_FRAGMENT
    if (frag_size_r == '0) begin
      frag_limit = CMP_W'(1);
    end else if (size_ext > CMP_W'(MAX_FRAGMENT)) begin
      frag_limit = CMP_W'(MAX_FRAGMENT);
    end else begin
      frag_limit = size_ext;
    end
    // Saturate the position count at MAX_FRAGMENT
    pos_inc  = (pos_r < POS_W'(MAX_FRAGMENT)) ? pos_r + POS_W'(1) : pos_r;
    frag_end = in_ch.end_of_message || (CMP_W'(pos_inc) >= frag_limit);
  end

  always_comb begin
    enc_char  = '0;
    enc_cnt   = CNT_W'(1);
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    pos_nxt   = pos_r;
    case (phase_r)
      PH_FIRST: begin
        enc_char[0] = sextet_char(b[7:2]);
        if (frag_end) begin
          // One byte of a group: one more sextet, then two pads
          enc_char[1] = sextet_char({b[1:0], 4'b0000});
          enc_char[2] = PAD_CHAR;
          enc_char[3] = PAD_CHAR;
          enc_cnt     = CNT_W'(4);
        end
        carry_nxt = {2'b00, b[1:0]};
        phase_nxt = PH_SECOND;
      end
      PH_SECOND: begin
        enc_char[0] = sextet_char({carry_r[1:0], b[7:4]});
        if (frag_end) begin
          // Two bytes of a group: one more sextet, then one pad
          enc_char[1] = sextet_char({b[3:0], 2'b00});
          enc_char[2] = PAD_CHAR;
          enc_cnt     = CNT_W'(3);
        end
        carry_nxt = b[3:0];
        phase_nxt = PH_THIRD;
      end
      default: begin
        // Group complete: two sextets, nothing to pad
        enc_char[0] = sextet_char({carry_r, b[7:6]});
        enc_char[1] = sextet_char(b[5:0]);
        enc_cnt     = CNT_W'(2);
        carry_nxt   = '0;
        phase_nxt   = PH_FIRST;
      end
    endcase
    pos_nxt = pos_inc;
    if (frag_end) begin
      // Restart group and fragment on the next byte
      phase_nxt = PH_FIRST;
      carry_nxt = '0;
      pos_nxt   = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frag_size_r <= FRAG_SIZE_RST;
      phase_r     <= PH_FIRST;
      carry_r     <= '0;
      pos_r       <= '0;
      buf_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        frag_size_r <= pwdata[FRAG_SIZE_W-1:0];
      end
      if (in_acc) begin
        phase_r   <= phase_nxt;
        carry_r   <= carry_nxt;
        pos_r     <= pos_nxt;
        buf_cnt_r <= enc_cnt;
      end else if (move) begin
        buf_cnt_r <= buf_cnt_r - CNT_W'(1);
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      buf_char_r <= enc_char;
      buf_eof_r  <= frag_end;
      buf_eot_r  <= in_ch.end_of_message;
    end else if (move) begin
      // Shift the next character to the head
      for (int i = 0; i < MAX_CHARS - 1; i++) begin
        buf_char_r[i] <= buf_char_r[i+1];
      end
      buf_char_r[MAX_CHARS-1] <= '0;
    end
    if (move) begin
      out_char_r <= buf_char_r[0];
      // Flags ride only on the byte's final character
      out_last_r <= (buf_cnt_r == CNT_W'(1));
      out_eof_r  <= (buf_cnt_r == CNT_W'(1)) && buf_eof_r;
      out_eot_r  <= (buf_cnt_r == CNT_W'(1)) && buf_eot_r;
    end
  end

endmodule

// ===== hw/rtl/fbe_checker.sv =====
// Port-level assertions for the fragmented base64 encoder, bound to the top level.
`timescale 1ns / 1ps

module fbe_checker (
  input logic        clk,
  input logic        rst_n,
  fbe_in_if.sink     in_ch,
  fbe_out_if.source  out_ch
);

  // A waiting word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result word dropped while stalled");

  // Message end always closes a fragment on the same character
  a_eot_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.end_of_text |-> out_ch.end_of_fragment)
    else $error("end_of_text without end_of_fragment");

  // A fragment only ends on the last character of a byte
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.end_of_fragment |-> out_ch.run_last)
    else $error("end_of_fragment before run_last");

  // With no word offered and no byte taken last cycle, nothing is buffered,
  // so the input side must be ready
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(in_ch.valid && in_ch.ready) && !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with nothing buffered or offered");

endmodule

bind fragmented_base64_encoder fbe_checker u_fbe_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
